// ===== sv/pst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants of the periodic soft timer scheduler
// Slot table geometry, opcodes, result kinds and status codes.
// ----------------------------------------------------------------------------
package pst_pkg;

  // Slot table geometry
  localparam int unsigned SLOTS = 16;
  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SlotW = 4;
  localparam int unsigned TickW = 32;

  // Opcodes
  typedef enum logic [3:0] {
    OP_PERIODIC = 4'd0,
    OP_HANDLER  = 4'd1,
    OP_CREATE   = 4'd2,
    OP_DELETE   = 4'd3,
    OP_PAUSE    = 4'd4,
    OP_RESUME   = 4'd5,
    OP_PERIOD   = 4'd6,
    OP_READY    = 4'd7,
    OP_RESTART  = 4'd8,
    OP_REPEAT   = 4'd9
  } op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_EVENT   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_INACTIVE = 2'd2
  } status_e;

  // Repeat count written by create: run forever
  localparam logic [TickW-1:0] RepeatForever = '1;
  // Wait reported when no timer is pending
  localparam logic [TickW-1:0] NoTimer = '1;
  // Wait reported by a disabled handler transaction
  localparam logic [TickW-1:0] DisabledWait = TickW'(1);

  // One row of the slot memory
  typedef struct packed {
    logic [TickW-1:0] period;
    logic [TickW-1:0] run_tick;
    logic [TickW-1:0] rpt;
  } row_t;

  // One result transaction
  typedef struct packed {
    kind_e            kind;
    logic [SlotW-1:0] rslot;
    status_e          status;
    logic             fired;
    logic             freed;
    logic             ran;
    logic [TickW-1:0] wait_ms;
    logic             last;
  } res_t;

endpackage

// ===== sv/periodic_soft_timer_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_soft_timer_scheduler: table of software timer slots
// Slot period, last-run tick and repeat count live in one synchronous memory;
// valid and paused bits live in flops. A handler transaction scans the table.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ----------------------------------------
//  in       in_valid_i/in_ready_o  opcode, slot, period_ms, repeat_value, now
//  out      out_valid_o/out_ready_i kind, result_slot, status, fired, freed,
//                                  ran, wait_ms, last
//  cfg      cfg_we_i               cfg_wdata_i (enable)
//
//  A table operation is accepted, then its row is read-modify-written in S_OP.
//  A handler run does one memory read per slot, pipelined one slot per cycle
//  unless a waiting event stalls the scan, then issues a summary result.
//  Reset clears valid/paused bits and control; the memory needs no clearing.
//  A full output register stalls the scan at the slot whose event waits.
//  A new transaction is taken once the previous one has issued its last result.
//
module periodic_soft_timer_scheduler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [3:0]                  opcode_i,
  input  logic [pst_pkg::SlotW-1:0]   slot_i,
  input  logic [pst_pkg::TickW-1:0]   period_ms_i,
  input  logic signed [pst_pkg::TickW-1:0] repeat_value_i,
  input  logic [pst_pkg::TickW-1:0]   now_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  kind_o,
  output logic [pst_pkg::SlotW-1:0]   result_slot_o,
  output logic [1:0]                  status_o,
  output logic                        fired_o,
  output logic                        freed_o,
  output logic                        ran_o,
  output logic [pst_pkg::TickW-1:0]   wait_ms_o,
  output logic                        last_o
);
  import pst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OP   = 4'b0010,
    S_SCAN = 4'b0100,
    S_SUM  = 4'b1000
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  // Control state
  state_e            state_q, state_d;
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [SLOTS-1:0]  paused_q, paused_d;
  logic              enable_q, enable_d;
  logic [TickW-1:0]  sw_q, sw_d;       // stored wait
  logic [TickW-1:0]  plast_q, plast_d; // last periodic run
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [TickW-1:0]  best_q, best_d;

  // Latched transaction
  op_e               op_q, op_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [TickW-1:0]  per_q, per_d;
  logic [TickW-1:0]  rep_q, rep_d;
  logic [TickW-1:0]  now_q, now_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  res_t              res_q;
  res_t              res;
  logic              emit;
  logic              out_free;

  // Slot memory
  row_t              mem [SLOTS];
  row_t              rdata_q;
  logic [IdxW-1:0]   rd_addr;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  row_t              mem_wrow;

  // Scan datapath
  logic              act;
  logic [TickW-1:0]  elp;
  logic              due;
  logic [TickW-1:0]  rem0;
  logic [TickW-1:0]  new_rep;
  logic              fired;
  logic              freed;
  logic [TickW-1:0]  next_wait;
  logic              need_evt;
  logic              scan_adv;

  // Misc decode
  logic [IdxW-1:0]   slot_idx;
  logic              slot_ok;
  logic              scan_op;
  logic              any_free;
  logic [IdxW-1:0]   free_idx;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign slot_idx   = IdxW'(slot_q);
  assign slot_ok    = (32'(slot_q) < SLOTS) && valid_q[slot_idx];
  assign scan_op    = (op_q == OP_PERIODIC) || (op_q == OP_HANDLER);

  // Lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        any_free = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  // Per-slot evaluation of the row under the scan pointer
  always_comb begin
    act       = valid_q[idx_q] && !paused_q[idx_q];
    elp       = now_q - rdata_q.run_tick;
    due       = (elp >= rdata_q.period);
    rem0      = rdata_q.period - elp;
    new_rep   = (due && (rdata_q.rpt != '0) && !rdata_q.rpt[TickW-1])
                ? rdata_q.rpt - TickW'(1) : rdata_q.rpt;
    fired     = due && (rdata_q.rpt != '0);
    freed     = (new_rep == '0);
    next_wait = due ? rdata_q.period : rem0;
    need_evt  = act && (due || freed);
    scan_adv  = !need_evt || out_free;
  end

  // Memory read address
  always_comb begin
    rd_addr = idx_q;
    unique case (state_q)
      S_IDLE:  rd_addr = IdxW'(slot_i);
      S_OP:    rd_addr = scan_op ? '0 : slot_idx;
      S_SCAN:  rd_addr = scan_adv ? idx_q + IdxW'(1) : idx_q;
      S_SUM:   rd_addr = idx_q;
      default: rd_addr = idx_q;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    paused_d  = paused_q;
    enable_d  = enable_q;
    sw_d      = sw_q;
    plast_d   = plast_q;
    idx_d     = idx_q;
    best_d    = best_q;
    op_d      = op_q;
    slot_d    = slot_q;
    per_d     = per_q;
    rep_d     = rep_q;
    now_d     = now_q;
    emit      = 1'b0;
    res       = '0;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wrow  = rdata_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_e'(opcode_i);
          slot_d  = slot_i;
          per_d   = period_ms_i;
          rep_d   = repeat_value_i;
          now_d   = now_i;
          state_d = S_OP;
        end
      end

      S_OP: begin
        res.last = 1'b1;
        case (op_q) inside
          OP_PERIODIC, OP_HANDLER: begin
            res.kind = KIND_SUMMARY;
            if ((op_q == OP_PERIODIC) && ((now_q - plast_q) < sw_q)) begin
              // not yet due: report stored wait
              res.wait_ms = sw_q;
              if (out_free) begin
                emit    = 1'b1;
                state_d = S_IDLE;
              end
            end else if (enable_q) begin
              if (op_q == OP_PERIODIC) plast_d = now_q;
              best_d  = NoTimer;
              idx_d   = '0;
              state_d = S_SCAN;
            end else begin
              res.wait_ms = DisabledWait;
              if (out_free) begin
                if (op_q == OP_PERIODIC) plast_d = now_q;
                emit    = 1'b1;
                state_d = S_IDLE;
              end
            end
          end

          OP_CREATE: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = S_IDLE;
              if (any_free) begin
                valid_d[free_idx]  = 1'b1;
                paused_d[free_idx] = 1'b0;
                mem_we             = 1'b1;
                mem_waddr          = free_idx;
                mem_wrow.period    = per_q;
                mem_wrow.run_tick  = now_q;
                mem_wrow.rpt       = RepeatForever;
                sw_d               = '0;
                res.rslot          = SlotW'(free_idx);
              end else begin
                res.status = ST_NO_FREE;
              end
            end
          end

          OP_DELETE, OP_PAUSE, OP_RESUME, OP_PERIOD, OP_READY, OP_RESTART,
          OP_REPEAT: begin
            res.rslot = slot_q;
            if (out_free) begin
              emit      = 1'b1;
              state_d   = S_IDLE;
              mem_waddr = slot_idx;
              if (!slot_ok) begin
                res.status = ST_INACTIVE;
              end else begin
                case (op_q)
                  OP_DELETE: valid_d[slot_idx] = 1'b0;
                  OP_PAUSE:  paused_d[slot_idx] = 1'b1;
                  OP_RESUME: begin
                    paused_d[slot_idx] = 1'b0;
                    sw_d               = '0;
                  end
                  OP_PERIOD: begin
                    mem_we          = 1'b1;
                    mem_wrow.period = per_q;
                  end
                  OP_READY: begin
                    mem_we            = 1'b1;
                    mem_wrow.run_tick = now_q - rdata_q.period - TickW'(1);
                  end
                  OP_RESTART: begin
                    mem_we            = 1'b1;
                    mem_wrow.run_tick = now_q;
                    sw_d              = '0;
                  end
                  default: begin
                    mem_we       = 1'b1;
                    mem_wrow.rpt = rep_q;
                  end
                endcase
              end
            end
          end

          default: begin
            // unused opcode: plain acknowledge
            if (out_free) begin
              emit    = 1'b1;
              state_d = S_IDLE;
            end
          end
        endcase
      end

      S_SCAN: begin
        res.kind  = KIND_EVENT;
        res.rslot = SlotW'(idx_q);
        res.fired = fired;
        res.freed = freed;
        if (scan_adv) begin
          emit = need_evt;
          if (act) begin
            if (due) begin
              mem_we            = 1'b1;
              mem_wrow.run_tick = now_q;
              mem_wrow.rpt      = new_rep;
            end
            if (freed) begin
              valid_d[idx_q] = 1'b0;
            end else if (next_wait < best_q) begin
              best_d = next_wait;
            end
          end
          idx_d = idx_q + IdxW'(1);
          if (idx_q == LastIdx) state_d = S_SUM;
        end
      end

      S_SUM: begin
        res.kind    = KIND_SUMMARY;
        res.ran     = 1'b1;
        res.wait_ms = best_q;
        res.last    = 1'b1;
        if (out_free) begin
          emit    = 1'b1;
          sw_d    = best_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // Configuration write: the user writes only while idle; the block does not enforce it
    if (cfg_we_i) begin
      enable_d = cfg_wdata_i;
      if (cfg_wdata_i) sw_d = '0;
    end

    out_valid_d = emit || (out_valid_q && !out_ready_i);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      paused_q    <= '0;
      enable_q    <= 1'b1;
      sw_q        <= '0;
      plast_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      paused_q    <= paused_d;
      enable_q    <= enable_d;
      sw_q        <= sw_d;
      plast_q     <= plast_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    op_q   <= op_d;
    slot_q <= slot_d;
    per_q  <= per_d;
    rep_q  <= rep_d;
    now_q  <= now_d;
    if (emit) res_q <= res;
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wrow;
    rdata_q <= mem[rd_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = res_q.kind;
  assign result_slot_o = res_q.rslot;
  assign status_o      = res_q.status;
  assign fired_o       = res_q.fired;
  assign freed_o       = res_q.freed;
  assign ran_o         = res_q.ran;
  assign wait_ms_o     = res_q.wait_ms;
  assign last_o        = res_q.last;

  // Assertions
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && out_valid_q |-> out_ready_i)
    else $error("result register overwritten while full");

  a_event_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_EVENT) |-> !last_o)
    else $error("slot event flagged as last result");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && scan_adv && (idx_q != LastIdx)
      |=> (state_q == S_SCAN) && (idx_q == $past(idx_q) + IdxW'(1)))
    else $error("scan skipped or repeated a slot");

  a_freed_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && scan_adv && act && freed |=> !valid_q[$past(idx_q)])
    else $error("freed slot still valid");

  a_sum_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) && out_free |=> (state_q == S_IDLE) && out_valid_o && last_o)
    else $error("summary not issued as final result");

endmodule

// ===== tb/periodic_soft_timer_scheduler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_soft_timer_scheduler_test: self-checking bench for the timer table
// Sends directed and random table, handler and periodic transactions with
// random gaps on both channels. A scoreboard keeps its own copy of the slot
// table, predicts every result transaction and compares each one field by field.
// ----------------------------------------------------------------------------
module periodic_soft_timer_scheduler_test;
  import pst_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 30;
  localparam int unsigned IdlePct       = 8;
  localparam int unsigned OpCodes       = 16;
  localparam int unsigned MainItems     = 180;
  localparam int unsigned DisabledItems = 50;
  localparam int unsigned FinalItems    = 190;
  localparam int unsigned SteadyItems   = 100;

  // Scoreboard: private copy of the timer table plus the expected results
  class timer_scoreboard;
    bit               tbl_valid [SLOTS];
    bit               tbl_paused[SLOTS];
    logic [TickW-1:0] tbl_period[SLOTS];
    logic [TickW-1:0] tbl_last  [SLOTS];
    logic [TickW-1:0] tbl_rpt   [SLOTS];
    logic [TickW-1:0] wait_store;
    logic [TickW-1:0] periodic_stamp;
    bit               enabled;
    res_t             outstanding_results[$];
    int unsigned      mismatches;
    int unsigned      results_checked;
    int unsigned      passes_run;
    int unsigned      timers_fired;
    int unsigned      timers_freed;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        tbl_valid[i]  = 1'b0;
        tbl_paused[i] = 1'b0;
        tbl_period[i] = '0;
        tbl_last[i]   = '0;
        tbl_rpt[i]    = '0;
      end
      wait_store      = '0;
      periodic_stamp  = '0;
      enabled         = 1'b1;
      mismatches      = 0;
      results_checked = 0;
      passes_run      = 0;
      timers_fired    = 0;
      timers_freed    = 0;
    endfunction

    function void set_enable(bit v);
      enabled = v;
      if (v) wait_store = '0;
    endfunction

    function void queue_result(kind_e k, logic [SlotW-1:0] s, status_e st, bit fi,
                               bit fr, bit r, logic [TickW-1:0] w);
      res_t e;
      e.kind    = k;
      e.rslot   = s;
      e.status  = st;
      e.fired   = fi;
      e.freed   = fr;
      e.ran     = r;
      e.wait_ms = w;
      e.last    = 1'b0;
      outstanding_results.push_back(e);
    endfunction

    // Ticks until slot i is due; zero once the period has elapsed
    function logic [TickW-1:0] time_left(int i, logic [TickW-1:0] now);
      logic [TickW-1:0] elapsed;
      elapsed = now - tbl_last[i];
      return (elapsed >= tbl_period[i]) ? '0 : tbl_period[i] - elapsed;
    endfunction

    // One handler pass over the table in ascending slot order
    function void scan_timers(logic [TickW-1:0] now);
      logic [TickW-1:0] best;
      logic [TickW-1:0] orig;
      logic [TickW-1:0] d;
      bit due, fired, freed;
      if (!enabled) begin
        queue_result(KIND_SUMMARY, '0, ST_OK, 1'b0, 1'b0, 1'b0, DisabledWait);
        return;
      end
      best = NoTimer;
      for (int i = 0; i < SLOTS; i++) begin
        if (!tbl_valid[i] || tbl_paused[i]) continue;
        due   = 1'b0;
        fired = 1'b0;
        freed = 1'b0;
        if (time_left(i, now) == '0) begin
          orig = tbl_rpt[i];
          due  = 1'b1;
          // negative counts run forever
          if (orig != '0 && !orig[TickW-1]) tbl_rpt[i] = orig - 1'b1;
          tbl_last[i] = now;
          fired = (orig != '0);
        end
        if (tbl_rpt[i] == '0) begin
          tbl_valid[i] = 1'b0;
          freed = 1'b1;
        end else begin
          d = time_left(i, now);
          if (d < best) best = d;
        end
        if (due || freed)
          queue_result(KIND_EVENT, SlotW'(i), ST_OK, fired, freed, 1'b0, '0);
      end
      wait_store = best;
      queue_result(KIND_SUMMARY, '0, ST_OK, 1'b0, 1'b0, 1'b1, best);
    endfunction

    // Accepted input transaction: update the table, queue its results
    function void note_command(logic [3:0] op, logic [SlotW-1:0] sl,
                               logic [TickW-1:0] per, logic [TickW-1:0] rpt,
                               logic [TickW-1:0] now);
      int free_idx;
      free_idx = -1;
      case (op)
        OP_PERIODIC: begin
          if (now - periodic_stamp >= wait_store) begin
            scan_timers(now);
            periodic_stamp = now;
          end else begin
            queue_result(KIND_SUMMARY, '0, ST_OK, 1'b0, 1'b0, 1'b0, wait_store);
          end
        end
        OP_HANDLER: scan_timers(now);
        OP_CREATE: begin
          for (int i = SLOTS - 1; i >= 0; i--) if (!tbl_valid[i]) free_idx = i;
          if (free_idx < 0) begin
            queue_result(KIND_ACK, '0, ST_NO_FREE, 1'b0, 1'b0, 1'b0, '0);
          end else begin
            tbl_valid[free_idx]  = 1'b1;
            tbl_paused[free_idx] = 1'b0;
            tbl_period[free_idx] = per;
            tbl_rpt[free_idx]    = RepeatForever;
            tbl_last[free_idx]   = now;
            wait_store = '0;
            queue_result(KIND_ACK, SlotW'(free_idx), ST_OK, 1'b0, 1'b0, 1'b0, '0);
          end
        end
        OP_DELETE, OP_PAUSE, OP_RESUME, OP_PERIOD, OP_READY, OP_RESTART,
        OP_REPEAT: begin
          if (!tbl_valid[sl]) begin
            queue_result(KIND_ACK, sl, ST_INACTIVE, 1'b0, 1'b0, 1'b0, '0);
          end else begin
            case (op)
              OP_DELETE:  tbl_valid[sl] = 1'b0;
              OP_PAUSE:   tbl_paused[sl] = 1'b1;
              OP_RESUME: begin
                tbl_paused[sl] = 1'b0;
                wait_store = '0;
              end
              OP_PERIOD:  tbl_period[sl] = per;
              OP_READY:   tbl_last[sl] = now - tbl_period[sl] - 1'b1;
              OP_RESTART: begin
                tbl_last[sl] = now;
                wait_store = '0;
              end
              default:    tbl_rpt[sl] = rpt;
            endcase
            queue_result(KIND_ACK, sl, ST_OK, 1'b0, 1'b0, 1'b0, '0);
          end
        end
        // unused opcodes are acknowledged and ignored
        default: queue_result(KIND_ACK, '0, ST_OK, 1'b0, 1'b0, 1'b0, '0);
      endcase
      outstanding_results[$].last = 1'b1;
    endfunction

    function void check_field(string name, logic [TickW-1:0] expv, logic [TickW-1:0] actv);
      if (expv !== actv) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
        mismatches++;
      end
    endfunction

    // Accepted result transaction against the oldest expectation
    function void check_result(logic [1:0] kind, logic [SlotW-1:0] rslot,
                               logic [1:0] status, logic fired, logic freed, logic ran,
                               logic [TickW-1:0] wait_ms, logic last);
      res_t e;
      if (outstanding_results.size() == 0) begin
        $error("result with nothing expected: kind %0d slot %0d", kind, rslot);
        mismatches++;
        return;
      end
      e = outstanding_results.pop_front();
      results_checked++;
      if (e.kind == KIND_SUMMARY && e.ran) passes_run++;
      if (e.fired) timers_fired++;
      if (e.freed) timers_freed++;
      check_field("kind", TickW'(e.kind), TickW'(kind));
      check_field("result_slot", TickW'(e.rslot), TickW'(rslot));
      check_field("status", TickW'(e.status), TickW'(status));
      check_field("fired", TickW'(e.fired), TickW'(fired));
      check_field("freed", TickW'(e.freed), TickW'(freed));
      check_field("ran", TickW'(e.ran), TickW'(ran));
      check_field("wait_ms", e.wait_ms, wait_ms);
      check_field("last", TickW'(e.last), TickW'(last));
    endfunction

    // Mostly aim at live slots so table operations do real work
    function logic [SlotW-1:0] pick_slot();
      int live[$];
      for (int i = 0; i < SLOTS; i++) if (tbl_valid[i]) live.push_back(i);
      if (live.size() == 0 || $urandom_range(0, 99) < 15) return SlotW'($urandom);
      return SlotW'(live[$urandom_range(0, live.size() - 1)]);
    endfunction
  endclass

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_we_i       = 1'b0;
  logic                    cfg_wdata_i    = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic [3:0]              opcode_i       = '0;
  logic [SlotW-1:0]        slot_i         = '0;
  logic [TickW-1:0]        period_ms_i    = '0;
  logic signed [TickW-1:0] repeat_value_i = '0;
  logic [TickW-1:0]        now_i          = '0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b0;
  logic [1:0]              kind_o;
  logic [SlotW-1:0]        result_slot_o;
  logic [1:0]              status_o;
  logic                    fired_o;
  logic                    freed_o;
  logic                    ran_o;
  logic [TickW-1:0]        wait_ms_o;
  logic                    last_o;

  timer_scoreboard  sb = new();
  bit               steady = 1'b0;
  logic [TickW-1:0] tick = 32'hFFFF_FFC0;
  int unsigned      items_sent = 0;
  int unsigned      quiet_cycles = 0;

  periodic_soft_timer_scheduler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .slot_i        (slot_i),
    .period_ms_i   (period_ms_i),
    .repeat_value_i(repeat_value_i),
    .now_i         (now_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .result_slot_o (result_slot_o),
    .status_o      (status_o),
    .fired_o       (fired_o),
    .freed_o       (freed_o),
    .ran_o         (ran_o),
    .wait_ms_o     (wait_ms_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  // Result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(kind_o, result_slot_o, status_o, fired_o, freed_o, ran_o,
                        wait_ms_o, last_o);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("watchdog: %0d cycles without a transaction", quiet_cycles);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // One input transaction, with random gaps before it
  task automatic send_command(logic [3:0] op, logic [SlotW-1:0] sl, logic [TickW-1:0] per,
                              logic signed [TickW-1:0] rpt, logic [TickW-1:0] now);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    slot_i         <= sl;
    period_ms_i    <= per;
    repeat_value_i <= rpt;
    now_i          <= now;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(op, sl, per, rpt, now);
    items_sent++;
  endtask

  task automatic send_next(logic [3:0] op, logic [SlotW-1:0] sl, logic [TickW-1:0] per,
                           logic signed [TickW-1:0] rpt);
    tick = tick + 3;
    send_command(op, sl, per, rpt, tick);
  endtask

  // Stop sending and wait for every expected result
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.outstanding_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_enable(bit v);
    drain();
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_enable(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random transaction: mostly live timers with short periods and a
  // steadily advancing tick, some noise in every field
  task automatic send_random_item();
    logic [3:0]              op;
    logic [TickW-1:0]        per;
    logic signed [TickW-1:0] rpt;
    int unsigned             roll;
    roll = $urandom_range(0, 99);
    if (roll < 12)      op = OP_HANDLER;
    else if (roll < 22) op = OP_PERIODIC;
    else if (roll < 36) op = OP_CREATE;
    else if (roll < 43) op = OP_DELETE;
    else if (roll < 50) op = OP_PAUSE;
    else if (roll < 58) op = OP_RESUME;
    else if (roll < 65) op = OP_PERIOD;
    else if (roll < 73) op = OP_READY;
    else if (roll < 80) op = OP_RESTART;
    else if (roll < 96) op = OP_REPEAT;
    else                op = 4'($urandom_range(OP_REPEAT + 1, OpCodes - 1));
    roll = $urandom_range(0, 99);
    if (roll < 80)      per = $urandom_range(0, 40);
    else if (roll < 90) per = $urandom_range(0, 5000);
    else                per = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 30)      rpt = RepeatForever;
    else if (roll < 80) rpt = $urandom_range(0, 4);
    else                rpt = $urandom_range(0, 32'h7FFF_FFFF);
    // occasional jump of the tick, backwards too
    if ($urandom_range(0, 99) < 4) tick = $urandom;
    else                           tick = tick + $urandom_range(0, 15);
    send_command(op, sb.pick_slot(), per, rpt, tick);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_enable(1'b1);

    // Directed: fill the table past full, then every operation at least once
    for (int i = 0; i <= SLOTS; i++)
      send_next(OP_CREATE, '0, (i == 0) ? '0 : (i == 1) ? '1 : TickW'(i * 3), '0);
    send_next(OP_DELETE, 4'd3, '0, '0);
    send_next(OP_RESUME, 4'd3, '0, '0);
    send_next(OP_PAUSE, 4'd2, '0, '0);
    send_next(OP_PERIOD, 4'd5, '1, '0);
    send_next(OP_READY, 4'd4, '0, '0);
    send_next(OP_RESTART, 4'd6, '0, '0);
    send_next(OP_REPEAT, 4'd0, '0, '0);
    send_next(OP_REPEAT, 4'd8, '0, 32'sd1);
    send_next(OP_REPEAT, 4'd7, '0, 32'sh7FFF_FFFF);
    send_next(OP_HANDLER, '0, '0, '0);
    send_next(OP_PERIODIC, '0, '0, '0);
    send_next(4'(OpCodes - 1), 4'hF, '1, RepeatForever);

    repeat (MainItems) send_random_item();

    // Handler runs held off
    write_enable(1'b0);
    repeat (DisabledItems) send_random_item();

    // Back on; first stretch with no gaps on either side
    write_enable(1'b1);
    steady = 1'b1;
    repeat (SteadyItems) send_random_item();
    steady = 1'b0;
    repeat (FinalItems - SteadyItems) send_random_item();

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d transactions, checked %0d results: %0d handler passes,",
             items_sent, sb.results_checked, sb.passes_run);
    $display("%0d timer expiries fired, %0d slots freed by repeat count",
             sb.timers_fired, sb.timers_freed);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pst_pkg.sv
sv/periodic_soft_timer_scheduler.sv
tb/periodic_soft_timer_scheduler_test.sv
